### rtl/core/hht_pkg.sv
// ----------------------------------------------------------------------------
// hht_pkg
// Shared widths, constants, controller states and the command and status
// structs of the hop health tracker.
// ----------------------------------------------------------------------------
package hht_pkg;

  localparam int unsigned NODES_DEF = 64;

  // Field widths.
  localparam int SLOT_W  = 6;
  localparam int RTT_W   = 24;
  localparam int CNT_W   = 16;
  localparam int INST_W  = 17;
  localparam int Q16_W   = 17;
  localparam int JIT_W   = 32;
  localparam int SLOT_SPAN = 1 << SLOT_W;

  // One slot of the health table: received count, RTT, jitter, loss.
  localparam int ENTRY_W = CNT_W + RTT_W + JIT_W + Q16_W;

  localparam logic [Q16_W-1:0] Q16_ONE  = 17'h10000;
  // RTT and jitter values at which their score factors reach 1.0.
  localparam logic [RTT_W-1:0] RTT_FULL = 24'd200000;
  localparam logic [JIT_W-1:0] JIT_FULL = 32'd25600000;

  // Both factors reduce to x / 3125 with x = rtt * 1024 or x = jitter * 8.
  localparam int unsigned FACTOR_DIV = 3125;
  localparam int FACTOR_XW  = 28;
  localparam int unsigned SCORE_DIV  = 100;
  localparam int SUM_W      = 23;

  localparam logic [SUM_W-1:0] W_LOSS = 23'd50;
  localparam logic [SUM_W-1:0] W_RTT  = 23'd20;
  localparam logic [SUM_W-1:0] W_JIT  = 23'd15;
  localparam logic [SUM_W-1:0] W_INST = 23'd15;

  // Jitter average: (4 * old + 256 * delta) / 5, divided as two 18-bit
  // halves, the upper half's remainder carried into the lower one.
  localparam int JNUM_W = 36;
  localparam int JLO_W  = 18;
  localparam int JREM_W = 3;
  localparam int JDX_W  = JREM_W + JLO_W;
  localparam int JQ_W   = 18;
  localparam int unsigned JDIV_D = 5;

  // Sequencer step counts.
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] LOSS_LAST  = 5'd15;
  localparam logic [STEP_W-1:0] JHI_LATCH  = 5'd2;
  localparam logic [STEP_W-1:0] JLO_LATCH  = 5'd5;
  localparam logic [STEP_W-1:0] RTT_LATCH  = 5'd3;
  localparam logic [STEP_W-1:0] JIT_LOAD   = 5'd9;
  localparam logic [STEP_W-1:0] JIT_LATCH  = 5'd13;
  localparam logic [STEP_W-1:0] SCORE_WAIT = 5'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_SUM,
    ST_SCORE
  } state_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic div_step;
    logic jhi_latch;
    logic jlo_latch;
    logic rtt_latch;
    logic jit_load;
    logic jit_latch;
    logic sum;
    logic writeback;
    logic out_load;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } status_t;

endpackage

### rtl/core/hht_in_if.sv
// ----------------------------------------------------------------------------
// hht_in_if
// Probe report channel: valid/ready handshake and report fields.
// ----------------------------------------------------------------------------
interface hht_in_if import hht_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] node_slot;
  logic              new_node;
  logic [RTT_W-1:0]  rtt_us;
  logic [CNT_W-1:0]  sent_count;
  logic [CNT_W-1:0]  recv_count;
  logic [INST_W-1:0] instability;

  modport source (
    output valid, node_slot, new_node, rtt_us, sent_count, recv_count, instability,
    input  ready
  );
  modport sink (
    input  valid, node_slot, new_node, rtt_us, sent_count, recv_count, instability,
    output ready
  );
endinterface

### rtl/core/hht_out_if.sv
// ----------------------------------------------------------------------------
// hht_out_if
// Health result channel: valid/ready handshake and result fields.
// ----------------------------------------------------------------------------
interface hht_out_if import hht_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] timeout_count;
  logic [Q16_W-1:0] loss_q16;
  logic [JIT_W-1:0] jitter_q8;
  logic [Q16_W-1:0] score_q16;

  modport source (
    output valid, timeout_count, loss_q16, jitter_q8, score_q16,
    input  ready
  );
  modport sink (
    input  valid, timeout_count, loss_q16, jitter_q8, score_q16,
    output ready
  );
endinterface

### rtl/core/hht_ram.sv
// ----------------------------------------------------------------------------
// hht_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hht_ram import hht_pkg::*; #(
  parameter int WIDTH = ENTRY_W,
  parameter int DEPTH = NODES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/hht_cdiv.sv
// ----------------------------------------------------------------------------
// hht_cdiv
// Divide by a constant: reciprocal multiply, then one correction step.
// Free running: registered product, then registered estimate and check terms.
// ----------------------------------------------------------------------------
module hht_cdiv import hht_pkg::*; #(
  parameter int          XW = FACTOR_XW,
  parameter int          QW = Q16_W,
  parameter int unsigned D  = FACTOR_DIV
) (
  input  logic          clk,
  input  logic [XW-1:0] x,
  output logic [QW-1:0] q
);

  localparam int unsigned RECIP = (1 << XW) / D;
  localparam logic [XW-1:0] RECIP_V = XW'(RECIP);
  localparam logic [XW-1:0] D_V     = XW'(D);

  logic [2*XW-1:0] p;
  logic [XW-1:0]   x1;
  logic [XW-1:0]   x2;
  logic [QW-1:0]   q0;
  logic [XW-1:0]   m;
  logic [XW-1:0]   r;

  // The estimate is low by at most one because x stays below 2**XW.
  always_ff @(posedge clk) begin
    p  <= {{XW{1'b0}}, x} * {{XW{1'b0}}, RECIP_V};
    x1 <= x;
    q0 <= QW'(p[2*XW-1:XW]);
    m  <= p[2*XW-1:XW] * D_V;
    x2 <= x1;
  end

  assign r = x2 - m;
  assign q = q0 + QW'(r >= D_V);

endmodule

### rtl/core/hht_ctrl.sv
// ----------------------------------------------------------------------------
// hht_ctrl
// Sequencer: clearing pass, slot read, divider steps, score and result load.
// ----------------------------------------------------------------------------
module hht_ctrl import hht_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t            st, st_next;
  logic [STEP_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= ST_CLEAR;
      cnt <= '0;
    end else begin
      st  <= st_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    st_next  = st;
    cnt_next = cnt;
    in_ready = 1'b0;
    cmd      = '0;
    case (st)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clr_last) begin
          st_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          st_next  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.fetch = 1'b1;
        cnt_next  = '0;
        st_next   = ST_DIV;
      end
      ST_DIV: begin
        // Loss divider runs every step; the jitter average and the two
        // factor divisions are slotted in at fixed steps.
        cmd.div_step  = 1'b1;
        cmd.jhi_latch = (cnt == JHI_LATCH);
        cmd.jlo_latch = (cnt == JLO_LATCH);
        cmd.rtt_latch = (cnt == RTT_LATCH);
        cmd.jit_load  = (cnt == JIT_LOAD);
        cmd.jit_latch = (cnt == JIT_LATCH);
        cnt_next      = cnt + 1'b1;
        if (cnt == LOSS_LAST) begin
          cnt_next = '0;
          st_next  = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum       = 1'b1;
        cmd.writeback = 1'b1;
        cnt_next      = '0;
        st_next       = ST_SCORE;
      end
      ST_SCORE: begin
        if (cnt == SCORE_WAIT) begin
          if (status.out_free) begin
            cmd.out_load = 1'b1;
            st_next      = ST_IDLE;
          end
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      default: begin
        st_next = ST_CLEAR;
      end
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result loaded while the output register is still full");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (st == ST_DIV && cnt == LOSS_LAST) |=> (st == ST_SUM))
    else $error("loss division did not end after its last step");

endmodule

### rtl/core/hht_dp.sv
// ----------------------------------------------------------------------------
// hht_dp
// Datapath: health table, loss divider, jitter average, factor and score
// division, output register.
// ----------------------------------------------------------------------------
module hht_dp import hht_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic [SLOT_W-1:0] node_slot,
  input  logic              new_node,
  input  logic [RTT_W-1:0]  rtt_us,
  input  logic [CNT_W-1:0]  sent_count,
  input  logic [CNT_W-1:0]  recv_count,
  input  logic [INST_W-1:0] instability,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CNT_W-1:0]  timeout_count,
  output logic [Q16_W-1:0]  loss_q16,
  output logic [JIT_W-1:0]  jitter_q8,
  output logic [Q16_W-1:0]  score_q16
);

  localparam int AW = $clog2(NODES);

  // Slot numbers wrap around the table size.
  logic [AW-1:0] slot_lut [SLOT_SPAN];
  for (genvar g = 0; g < SLOT_SPAN; g++) begin : g_slot
    assign slot_lut[g] = AW'(g % NODES);
  end

  // Report registers.
  logic [AW-1:0]     slot_r;
  logic              fresh_r;
  logic [RTT_W-1:0]  rtt_r;
  logic [CNT_W-1:0]  sent_r;
  logic [CNT_W-1:0]  recv_r;
  logic [INST_W-1:0] inst_r;

  // Table access.
  logic [AW-1:0]      clr_addr;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ENTRY_W-1:0] old_entry;
  logic [CNT_W-1:0]   old_recv;
  logic [RTT_W-1:0]   old_rtt;
  logic [JIT_W-1:0]   old_jit;
  logic [Q16_W-1:0]   old_loss;

  // Working registers.
  logic [JIT_W-1:0]     old_jit_r;
  logic [Q16_W-1:0]     old_loss_r;
  logic [CNT_W-1:0]     tmo_r;
  logic [CNT_W-1:0]     lrem;
  logic [Q16_W-1:0]     lq;
  logic                 jupd_r;
  logic [JNUM_W-1:0]    jnum;
  logic                 jlo_r;
  logic [JQ_W-1:0]      jq_hi;
  logic [JQ_W-1:0]      jq_lo;
  logic [JREM_W-1:0]    jr_hi;
  logic [FACTOR_XW-1:0] x_fac;
  logic                 fac_sat;
  logic [Q16_W-1:0]     q_fac;
  logic [Q16_W-1:0]     rtt_f;
  logic [Q16_W-1:0]     jit_f;
  logic [SUM_W-1:0]     sum_r;
  logic [Q16_W-1:0]     q_score;

  // Combinational values.
  logic [CNT_W-1:0]  tmo_c;
  logic [RTT_W-1:0]  delta;
  logic [CNT_W:0]    ltry;
  logic              lge;
  logic [JDX_W-1:0]  jx;
  logic [JQ_W-1:0]   jq;
  logic [JDX_W-1:0]  jq5;
  logic [JREM_W-1:0] jrem;
  logic [JNUM_W-1:0] jquot;
  logic [JIT_W-1:0]  jit_new;
  logic [Q16_W-1:0]  loss_new;
  logic [Q16_W-1:0]  inst_f;
  logic [Q16_W-1:0]  score_c;

  // ---------------------------------------------------------------------------
  // Health table with clearing pass after reset.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign status.clr_last = (clr_addr == AW'(NODES - 1));

  assign ram_we    = cmd.clear | cmd.writeback;
  assign ram_waddr = cmd.clear ? clr_addr : slot_r;
  assign ram_wdata = cmd.clear ? '0 : {recv_r, rtt_r, jit_new, loss_new};

  hht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot_lut[node_slot]),
    .rdata (ram_rdata)
  );

  // A new node reads as a cleared slot.
  assign old_entry = fresh_r ? '0 : ram_rdata;
  assign {old_recv, old_rtt, old_jit, old_loss} = old_entry;

  // ---------------------------------------------------------------------------
  // Capture and setup.
  // ---------------------------------------------------------------------------
  assign tmo_c = (sent_r > recv_r) ? (sent_r - recv_r) : '0;
  assign delta = (rtt_r > old_rtt) ? (rtt_r - old_rtt) : (old_rtt - rtt_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_r  <= slot_lut[node_slot];
      fresh_r <= new_node;
      rtt_r   <= rtt_us;
      sent_r  <= sent_count;
      recv_r  <= recv_count;
      inst_r  <= instability;
    end
  end

  // ---------------------------------------------------------------------------
  // Loss divider: timeouts * 65536 / sent, one quotient bit per step.
  // The top quotient bit is set only when every probe timed out.
  // ---------------------------------------------------------------------------
  assign ltry = {lrem, 1'b0};
  assign lge  = (ltry >= {1'b0, sent_r});

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      tmo_r      <= tmo_c;
      old_jit_r  <= old_jit;
      old_loss_r <= old_loss;
      lrem       <= (tmo_c == sent_r) ? '0 : tmo_c;
      lq         <= Q16_W'(tmo_c == sent_r);
    end else if (cmd.div_step) begin
      lrem <= lge ? CNT_W'(ltry - {1'b0, sent_r}) : ltry[CNT_W-1:0];
      lq   <= {lq[Q16_W-2:0], lge};
    end
  end

  assign loss_new = (sent_r == '0) ? old_loss_r : lq;

  // ---------------------------------------------------------------------------
  // Jitter average: the numerator is divided by five in two reciprocal
  // passes, the upper half first and then the lower half with the upper
  // half's remainder in front of it.
  // ---------------------------------------------------------------------------
  assign jx    = jlo_r ? {jr_hi, jnum[JLO_W-1:0]} : JDX_W'(jnum[JNUM_W-1:JLO_W]);
  assign jq5   = JDX_W'({jq, 2'b00}) + JDX_W'(jq);
  assign jrem  = JREM_W'(jx - jq5);
  assign jquot = {jq_hi, jq_lo};

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      jupd_r <= (old_recv != recv_r) && (recv_r != '0);
      jnum   <= JNUM_W'({old_jit, 2'b00}) + JNUM_W'({delta, 8'h00});
      jlo_r  <= 1'b0;
    end else if (cmd.jhi_latch) begin
      jq_hi <= jq;
      jr_hi <= jrem;
      jlo_r <= 1'b1;
    end
    if (cmd.jlo_latch) begin
      jq_lo <= jq;
    end
  end

  hht_cdiv #(
    .XW (JDX_W),
    .QW (JQ_W),
    .D  (JDIV_D)
  ) u_jit_div (
    .clk (clk),
    .x   (jx),
    .q   (jq)
  );

  assign jit_new = !jupd_r ? old_jit_r :
                   (|jquot[JNUM_W-1:JIT_W]) ? '1 : jquot[JIT_W-1:0];

  // ---------------------------------------------------------------------------
  // RTT and jitter factors share one divide-by-3125 unit.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      fac_sat <= (rtt_r >= RTT_FULL);
      x_fac   <= (rtt_r >= RTT_FULL) ? '0 : {rtt_r[17:0], 10'b0};
    end else if (cmd.jit_load) begin
      fac_sat <= (jit_new >= JIT_FULL);
      x_fac   <= (jit_new >= JIT_FULL) ? '0 : {jit_new[24:0], 3'b0};
    end
    if (cmd.rtt_latch) begin
      rtt_f <= fac_sat ? Q16_ONE : q_fac;
    end
    if (cmd.jit_latch) begin
      jit_f <= fac_sat ? Q16_ONE : q_fac;
    end
  end

  hht_cdiv #(
    .XW (FACTOR_XW),
    .QW (Q16_W),
    .D  (FACTOR_DIV)
  ) u_fac_div (
    .clk (clk),
    .x   (x_fac),
    .q   (q_fac)
  );

  // ---------------------------------------------------------------------------
  // Weighted score.
  // ---------------------------------------------------------------------------
  assign inst_f = (inst_r > Q16_ONE) ? Q16_ONE : inst_r;

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sum_r <= SUM_W'(loss_new) * W_LOSS + SUM_W'(rtt_f) * W_RTT
             + SUM_W'(jit_f) * W_JIT + SUM_W'(inst_f) * W_INST;
    end
  end

  hht_cdiv #(
    .XW (SUM_W),
    .QW (Q16_W),
    .D  (SCORE_DIV)
  ) u_score_div (
    .clk (clk),
    .x   (sum_r),
    .q   (q_score)
  );

  assign score_c = (q_score > Q16_ONE) ? Q16_ONE : q_score;

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      timeout_count <= tmo_r;
      loss_q16      <= loss_new;
      jitter_q8     <= jit_new;
      score_q16     <= score_c;
    end
  end

  assign status.out_free = !out_valid || out_ready;

  a_no_wb_clear: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clear && cmd.writeback))
    else $error("slot write-back during the clearing pass");

  a_q16_range: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (loss_q16 <= Q16_ONE) && (score_q16 <= Q16_ONE))
    else $error("loss or score above 1.0");

  a_loss_kept: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && sent_r == '0) |=> (loss_q16 == $past(old_loss_r)))
    else $error("loss changed for a report with no probes sent");

endmodule

### rtl/core/hop_health_tracker.sv
// ----------------------------------------------------------------------------
// hop_health_tracker
// Per-node path health: timeouts, loss rate, smoothed jitter and a weighted
// health score from one probe report per transaction.
// ----------------------------------------------------------------------------
// A report is captured, its slot is read and it runs through the 16-step loss
// divider; it is then summed, written back, scored and loaded, and only then is the next report taken.
// A report is taken while the previous result still waits in the output
// register; the result load then holds until that register frees up.
// Reset: synchronous; a clearing pass over every slot zeroes the table and
// no report is taken until it ends.
// ----------------------------------------------------------------------------
module hop_health_tracker import hht_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input logic       clk,
  input logic       rst,
  hht_in_if.sink    probe,
  hht_out_if.source result
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  hht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (probe.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign probe.ready = in_ready;

  hht_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .node_slot     (probe.node_slot),
    .new_node      (probe.new_node),
    .rtt_us        (probe.rtt_us),
    .sent_count    (probe.sent_count),
    .recv_count    (probe.recv_count),
    .instability   (probe.instability),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .timeout_count (result.timeout_count),
    .loss_q16      (result.loss_q16),
    .jitter_q8     (result.jitter_q8),
    .score_q16     (result.score_q16)
  );

endmodule

### tb/sv/tb_hop_health_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hop_health_tracker
// Self-checking bench for the hop health tracker. Probe reports are queued
// by a stimulus process and driven onto the report channel with random gaps.
// Every accepted report is run through a fixed-point model of the per-slot
// health table. Each result is checked field by field against the oldest
// predicted result. Receiver stalls, a long output hold-off and drained
// pauses between phases exercise backpressure.
// ----------------------------------------------------------------------------
module tb_hop_health_tracker;
  import hht_pkg::*;

  localparam int NODES      = NODES_DEF;
  localparam int CYCLE_MAX  = 400000;
  localparam int HOLD_LEN   = 600;
  localparam int PHASE_ITEMS = 430;

  typedef struct packed {
    logic [SLOT_W-1:0] node_slot;
    logic              new_node;
    logic [RTT_W-1:0]  rtt_us;
    logic [CNT_W-1:0]  sent_count;
    logic [CNT_W-1:0]  recv_count;
    logic [INST_W-1:0] instability;
  } report_t;

  typedef struct packed {
    logic [CNT_W-1:0] timeout_count;
    logic [Q16_W-1:0] loss_q16;
    logic [JIT_W-1:0] jitter_q8;
    logic [Q16_W-1:0] score_q16;
  } health_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hht_in_if  probe ();
  hht_out_if result ();

  hop_health_tracker #(.NODES(NODES)) u_top (
    .clk    (clk),
    .rst    (rst),
    .probe  (probe),
    .result (result)
  );

  always #5 clk = ~clk;

  report_t pending_reports[$];
  health_t health_q[$];
  report_t offer;

  int send_idle_pct = 35;
  int recv_idle_pct = 57;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int mismatches    = 0;
  int cycles        = 0;

  // Model copy of the health table.
  logic [CNT_W-1:0] recv_tab [NODES];
  logic [RTT_W-1:0] rtt_tab  [NODES];
  logic [JIT_W-1:0] jit_tab  [NODES];
  logic [Q16_W-1:0] loss_tab [NODES];

  // Per-slot state of the stimulus generator, for plausible report sequences.
  int gen_sent [NODES];
  int gen_recv [NODES];
  int gen_rtt  [NODES];

  function automatic logic [Q16_W-1:0] sat_q16(logic [63:0] v);
    return (v > 64'(Q16_ONE)) ? Q16_ONE : v[Q16_W-1:0];
  endfunction

  function automatic health_t track_report(report_t r);
    int unsigned      s;
    logic [CNT_W-1:0] tmo;
    logic [63:0]      d;
    logic [63:0]      acc;
    logic [63:0]      rtt_f;
    logic [63:0]      jit_f;
    logic [63:0]      inst_f;
    health_t          h;
    s = r.node_slot % NODES;
    if (r.new_node) begin
      recv_tab[s] = '0;
      rtt_tab[s]  = '0;
      jit_tab[s]  = '0;
      loss_tab[s] = '0;
    end
    tmo = (r.sent_count > r.recv_count) ? r.sent_count - r.recv_count : '0;
    if (r.sent_count != 0)
      loss_tab[s] = sat_q16((64'(tmo) << 16) / 64'(r.sent_count));
    // Jitter moves only when a new reply count arrives.
    if (recv_tab[s] != r.recv_count && r.recv_count != 0) begin
      d = (r.rtt_us > rtt_tab[s]) ? 64'(r.rtt_us - rtt_tab[s]) : 64'(rtt_tab[s] - r.rtt_us);
      acc = (64'd4 * 64'(jit_tab[s]) + 64'd256 * d) / 64'd5;
      jit_tab[s] = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
    end
    recv_tab[s] = r.recv_count;
    rtt_tab[s]  = r.rtt_us;
    rtt_f  = 64'(sat_q16((64'(r.rtt_us) << 16) / 64'(RTT_FULL)));
    jit_f  = 64'(sat_q16((64'(jit_tab[s]) << 16) / 64'(JIT_FULL)));
    inst_f = 64'(sat_q16(64'(r.instability)));
    h.timeout_count = tmo;
    h.loss_q16      = loss_tab[s];
    h.jitter_q8     = jit_tab[s];
    h.score_q16     = sat_q16((64'd50 * 64'(loss_tab[s]) + 64'd20 * rtt_f
                               + 64'd15 * jit_f + 64'd15 * inst_f) / 64'd100);
    return h;
  endfunction

  task automatic queue_report(input logic [SLOT_W-1:0] slot, input logic fresh,
                              input logic [RTT_W-1:0] rtt, input logic [CNT_W-1:0] sent,
                              input logic [CNT_W-1:0] recv, input logic [INST_W-1:0] inst);
    report_t r;
    r.node_slot   = slot;
    r.new_node    = fresh;
    r.rtt_us      = rtt;
    r.sent_count  = sent;
    r.recv_count  = recv;
    r.instability = inst;
    pending_reports.push_back(r);
  endtask

  // Mostly per-slot sequences with growing counters and drifting RTT,
  // concentrated on a few busy slots; the rest are arbitrary reports.
  task automatic queue_random_reports(input int count);
    int slot;
    int fresh;
    int step;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 80) begin
        slot  = ($urandom_range(99) < 70) ? $urandom_range(7) : $urandom_range(NODES - 1);
        fresh = ($urandom_range(15) == 0);
        if (fresh != 0) begin
          gen_sent[slot] = 0;
          gen_recv[slot] = 0;
          gen_rtt[slot]  = $urandom_range(300000, 1000);
        end
        step = $urandom_range(6);
        gen_sent[slot] = (gen_sent[slot] + step) & 16'hFFFF;
        gen_recv[slot] = (gen_recv[slot] + $urandom_range(step)) & 16'hFFFF;
        if ($urandom_range(9) == 0)
          gen_rtt[slot] = $urandom_range(2000000);
        else
          gen_rtt[slot] = gen_rtt[slot] + $urandom_range(4000) - 2000;
        if (gen_rtt[slot] < 0)
          gen_rtt[slot] = 0;
        queue_report(SLOT_W'(slot), 1'(fresh), RTT_W'(gen_rtt[slot]),
                     CNT_W'(gen_sent[slot]), CNT_W'(gen_recv[slot]),
                     INST_W'($urandom_range(65536)));
      end else begin
        queue_report(SLOT_W'($urandom), 1'($urandom), RTT_W'($urandom),
                     CNT_W'($urandom), CNT_W'($urandom), INST_W'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_reports.size() != 0 || probe.valid || health_q.size() != 0)
      @(negedge clk);
  endtask

  // Report channel driver.
  always @(posedge clk) begin
    if (rst) begin
      probe.valid <= 1'b0;
    end else begin
      if (probe.valid && probe.ready)
        health_q.push_back(track_report(offer));
      if (!probe.valid || probe.ready) begin
        if (pending_reports.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offer = pending_reports.pop_front();
          probe.node_slot   <= offer.node_slot;
          probe.new_node    <= offer.new_node;
          probe.rtt_us      <= offer.rtt_us;
          probe.sent_count  <= offer.sent_count;
          probe.recv_count  <= offer.recv_count;
          probe.instability <= offer.instability;
          probe.valid       <= 1'b1;
        end else begin
          probe.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down in cycles.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result channel monitor and backpressure.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (health_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result transaction with no report pending: tmo=%0d loss=%0d",
                     result.timeout_count, result.loss_q16);
        end else begin
          health_t want;
          health_t got;
          want = health_q.pop_front();
          got.timeout_count = result.timeout_count;
          got.loss_q16      = result.loss_q16;
          got.jitter_q8     = result.jitter_q8;
          got.score_q16     = result.score_q16;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: exp/got tmo %0d/%0d loss %0d/%0d jitter %0d/%0d score %0d/%0d",
                       want.timeout_count, got.timeout_count, want.loss_q16, got.loss_q16,
                       want.jitter_q8, got.jitter_q8, want.score_q16, got.score_q16);
          end
        end
      end
      result.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_MAX) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    probe.valid       = 1'b0;
    probe.node_slot   = '0;
    probe.new_node    = 1'b0;
    probe.rtt_us      = '0;
    probe.sent_count  = '0;
    probe.recv_count  = '0;
    probe.instability = '0;
    result.ready      = 1'b0;
    for (int i = 0; i < NODES; i++) begin
      recv_tab[i] = '0;
      rtt_tab[i]  = '0;
      jit_tab[i]  = '0;
      loss_tab[i] = '0;
      gen_sent[i] = 0;
      gen_recv[i] = 0;
      gen_rtt[i]  = 10000;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed reports: field extremes, zero sent, more replies than probes,
    // unchanged reply count, new node, instability above one.
    queue_report(0,  1, 0,         0,     0,     0);
    queue_report(63, 1, 24'hFFFFFF, 16'hFFFF, 0, 17'h10000);
    queue_report(63, 0, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 17'h1FFFF);
    queue_report(63, 0, 0,         0,     1,     17'h10001);
    queue_report(5,  1, 200000,    10,    20,    0);
    queue_report(5,  0, 199999,    10,    10,    32768);
    queue_report(5,  0, 1000,      100,   10,    65535);
    queue_report(5,  1, 5000,      4,     3,     100);
    queue_report(5,  0, 2000,      1,     1,     0);
    queue_report(1,  1, 150,       3,     1,     0);
    queue_report(1,  0, 150,       65535, 1,     0);
    queue_report(2,  1, 70000,     1,     0,     65536);
    for (int i = 0; i < 8; i++)
      queue_report(10, (i == 0), (i % 2 == 0) ? 24'hFFFFFF : 24'h0,
                   CNT_W'(2 * i + 2), CNT_W'(i + 1), 17'h0AAAA << (i % 2));
    queue_report(10, 0, 24'h555555, 16'hAAAA, 16'h5555, 17'h15555);
    queue_report(11, 0, 24'hAAAAAA, 16'h5555, 16'hAAAA, 17'h0AAAA);
    queue_random_reports(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 57;
    recv_idle_pct = 35;
    queue_random_reports(PHASE_ITEMS);
    wait_drained();

    // No idling; a long output hold-off fills the pipeline and stalls input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_reports(PHASE_ITEMS);
    @(negedge clk);
    hold_req++;
    wait_drained();

    repeat (60) @(posedge clk);
    if (mismatches == 0 && health_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### hop_health_tracker.f
rtl/core/hht_pkg.sv
rtl/core/hht_in_if.sv
rtl/core/hht_out_if.sv
rtl/core/hht_ram.sv
rtl/core/hht_cdiv.sv
rtl/core/hht_ctrl.sv
rtl/core/hht_dp.sv
rtl/core/hop_health_tracker.sv
tb/sv/tb_hop_health_tracker.sv
